>>> hw/rtl/foot_sole_floor_snap_unit_macros.svh
// Assertion macros shared by the floor snap unit.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef FOOT_SOLE_FLOOR_SNAP_UNIT_MACROS_SVH
`define FOOT_SOLE_FLOOR_SNAP_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define FSFS_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("fsfs assertion failed");
`define FSFS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fsfs assertion failed");
`define FSFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fsfs assertion failed");
`else
`define FSFS_ASSERT_NEVER(label, clk, rst_n, cond)
`define FSFS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define FSFS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hw/rtl/fsfs_pkg.sv
// Shared types and constants of the floor snap unit.
// No dependencies; used by the point and configuration interfaces and all modules.
package fsfs_pkg;

	localparam int SLOT_W     = 3;
	localparam int DT_W       = 16;
	localparam int FLOOR_W    = 20;
	localparam int BAND_W     = 19;
	localparam int SPEED_W    = 16;
	localparam int SLOTS_W    = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;

	// Square magnitude is checked only on the low 16 bits of each axis.
	localparam int MAG_W = 16;
	localparam int ACC_W = 34;
	localparam int P_W   = 32;
	localparam int P2_W  = 64;

	localparam logic [DT_W-1:0] DT_MIN = 16'd66;

	localparam logic signed [FLOOR_W-1:0] FLOOR_RST = 20'sd0;
	localparam logic [BAND_W-1:0]         BAND_RST  = 19'd123;
	localparam logic [SPEED_W-1:0]        SPEED_RST = 16'd1024;
	localparam logic [SLOTS_W-1:0]        SLOTS_RST = 3'd6;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FLOOR_HEIGHT = 2'd0,
		REG_SNAP_BAND    = 2'd1,
		REG_STANCE_SPEED = 2'd2,
		REG_SLOTS_IN_USE = 2'd3
	} reg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SQX  = 5'b00010,
		ST_SQY  = 5'b00100,
		ST_SQZ  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	typedef struct packed {
		logic signed [FLOOR_W-1:0] floor_height;
		logic [BAND_W-1:0]         snap_band;
		logic [SPEED_W-1:0]        stance_speed_limit;
		logic [SLOTS_W-1:0]        slots_in_use;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic sq_x;
		logic sq_y;
		logic sq_z;
		logic finish;
	} cmd_t;

endpackage

>>> hw/rtl/fsfs_if.sv
// Channel interfaces of the floor snap unit: point input, height output
// and configuration write. Depends on fsfs_pkg for field widths.
interface fsfs_in_if #(parameter int POS_WIDTH = 20);
	logic                              valid;
	logic                              ready;
	logic [fsfs_pkg::SLOT_W-1:0]       slot;
	logic                              point_valid;
	logic signed [POS_WIDTH-1:0]       pos_x;
	logic signed [POS_WIDTH-1:0]       pos_y;
	logic signed [POS_WIDTH-1:0]       pos_z;
	logic [fsfs_pkg::DT_W-1:0]         frame_interval;

	modport source(output valid, slot, point_valid, pos_x, pos_y, pos_z, frame_interval,
		input ready);
	modport sink(input valid, slot, point_valid, pos_x, pos_y, pos_z, frame_interval,
		output ready);
endinterface

interface fsfs_out_if #(parameter int POS_WIDTH = 20);
	logic                        valid;
	logic                        ready;
	logic signed [POS_WIDTH-1:0] height_out;
	logic                        changed;

	modport source(output valid, height_out, changed, input ready);
	modport sink(input valid, height_out, changed, output ready);
endinterface

interface fsfs_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [fsfs_pkg::CFG_IDX_W-1:0]      index;
	logic [fsfs_pkg::CFG_DATA_W-1:0]     data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

>>> hw/rtl/foot_sole_floor_snap_unit.sv
// Foot-sole floor snap unit: clamps or snaps tracked sole heights to the floor.
// Uses fsfs_pkg, the fsfs interfaces, fsfs_cfg, fsfs_ctrl, fsfs_dp and the macro header.
//
// Channels: in_ch carries one sole point per transfer (slot, point_valid,
// pos_x/y/z, frame_interval); out_ch returns one grounded height and a
// changed flag for every point, in order. cfg_ch writes one register per
// transfer (0 floor height, 1 snap band, 2 stance speed limit, 3 slots in
// use); it is always ready and should only be used while the unit is idle.
// The unit works on one point at a time and takes no new point until it
// has gone through the accept step, the three passes of the shared
// squarer and the decision step.
// The result sits in an output register, so a new point can be accepted
// while the previous result waits. If the receiver stalls, the unit holds
// the next result in its decision step until the output register frees.
// Reset clears all slot histories, restores the register defaults
// (floor 0, band 123, speed limit 1024, six slots) and empties the output.
`include "foot_sole_floor_snap_unit_macros.svh"

module foot_sole_floor_snap_unit #(
	parameter int SOLE_SLOTS = 6,
	parameter int POS_WIDTH  = 20
) (
	input  logic       clk,
	input  logic       arst_n,
	fsfs_in_if.sink    in_ch,
	fsfs_out_if.source out_ch,
	fsfs_cfg_if.sink   cfg_ch
);

	fsfs_pkg::cfg_t cfg;
	fsfs_pkg::cmd_t cmd;

	fsfs_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_ch (cfg_ch),
		.cfg    (cfg)
	);

	fsfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd)
	);

	fsfs_dp #(
		.SOLE_SLOTS (SOLE_SLOTS),
		.POS_WIDTH  (POS_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg            (cfg),
		.slot           (in_ch.slot),
		.point_valid    (in_ch.point_valid),
		.pos_x          (in_ch.pos_x),
		.pos_y          (in_ch.pos_y),
		.pos_z          (in_ch.pos_z),
		.frame_interval (in_ch.frame_interval),
		.height_out     (out_ch.height_out),
		.changed        (out_ch.changed)
	);

	`FSFS_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_ch.valid && in_ch.ready,
		!in_ch.ready)
	`FSFS_ASSERT_IMPL(a_result_due, clk, arst_n, in_ch.valid && in_ch.ready,
		##4 (cmd.finish || (out_ch.valid && !out_ch.ready)))
	`FSFS_ASSERT_NEVER(a_no_overwrite, clk, arst_n,
		cmd.finish && out_ch.valid && !out_ch.ready)

endmodule

>>> hw/rtl/fsfs_cfg.sv
// Configuration register file of the floor snap unit.
// Depends on fsfs_pkg and the fsfs_cfg_if interface.
module fsfs_cfg (
	input  logic             clk,
	input  logic             arst_n,
	fsfs_cfg_if.sink         cfg_ch,
	output fsfs_pkg::cfg_t   cfg
);

	fsfs_pkg::cfg_t cfg_q;
	logic           wr_en;

	assign cfg_ch.ready = 1'b1;
	assign wr_en        = cfg_ch.valid & cfg_ch.ready;
	assign cfg          = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.floor_height       <= fsfs_pkg::FLOOR_RST;
			cfg_q.snap_band          <= fsfs_pkg::BAND_RST;
			cfg_q.stance_speed_limit <= fsfs_pkg::SPEED_RST;
			cfg_q.slots_in_use       <= fsfs_pkg::SLOTS_RST;
		end else if (wr_en) begin
			case (cfg_ch.index)
				fsfs_pkg::REG_FLOOR_HEIGHT: begin
					cfg_q.floor_height <= cfg_ch.data[fsfs_pkg::FLOOR_W-1:0];
				end
				fsfs_pkg::REG_SNAP_BAND: begin
					cfg_q.snap_band <= cfg_ch.data[fsfs_pkg::BAND_W-1:0];
				end
				fsfs_pkg::REG_STANCE_SPEED: begin
					cfg_q.stance_speed_limit <= cfg_ch.data[fsfs_pkg::SPEED_W-1:0];
				end
				fsfs_pkg::REG_SLOTS_IN_USE: begin
					cfg_q.slots_in_use <= cfg_ch.data[fsfs_pkg::SLOTS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

>>> hw/rtl/fsfs_ctrl.sv
// Sequencer of the floor snap unit: walks one point through the
// squaring steps and owns the output valid flag. Depends on fsfs_pkg.
module fsfs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output fsfs_pkg::cmd_t  cmd
);

	fsfs_pkg::state_t state_q;
	fsfs_pkg::state_t state_d;
	logic             out_valid_q;
	logic             out_free;

	assign in_ready  = (state_q == fsfs_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = ~out_valid_q | out_ready;

	always_comb begin
		cmd.load   = in_ready & in_valid;
		cmd.sq_x   = (state_q == fsfs_pkg::ST_SQX);
		cmd.sq_y   = (state_q == fsfs_pkg::ST_SQY);
		cmd.sq_z   = (state_q == fsfs_pkg::ST_SQZ);
		cmd.finish = (state_q == fsfs_pkg::ST_DONE) & out_free;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			fsfs_pkg::ST_IDLE: begin
				if (in_valid) state_d = fsfs_pkg::ST_SQX;
			end
			fsfs_pkg::ST_SQX:  state_d = fsfs_pkg::ST_SQY;
			fsfs_pkg::ST_SQY:  state_d = fsfs_pkg::ST_SQZ;
			fsfs_pkg::ST_SQZ:  state_d = fsfs_pkg::ST_DONE;
			fsfs_pkg::ST_DONE: begin
				if (out_free) state_d = fsfs_pkg::ST_IDLE;
			end
			default:           state_d = fsfs_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fsfs_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> hw/rtl/fsfs_dp.sv
// Datapath of the floor snap unit: per-slot history, speed test by
// squared magnitudes and the floor clamp/snap. Depends on fsfs_pkg.
module fsfs_dp #(
	parameter int SOLE_SLOTS = 6,
	parameter int POS_WIDTH  = 20
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fsfs_pkg::cmd_t                      cmd,
	input  fsfs_pkg::cfg_t                      cfg,
	input  logic [fsfs_pkg::SLOT_W-1:0]         slot,
	input  logic                                point_valid,
	input  logic signed [POS_WIDTH-1:0]         pos_x,
	input  logic signed [POS_WIDTH-1:0]         pos_y,
	input  logic signed [POS_WIDTH-1:0]         pos_z,
	input  logic [fsfs_pkg::DT_W-1:0]           frame_interval,
	output logic signed [POS_WIDTH-1:0]         height_out,
	output logic                                changed
);

	localparam int SW  = (SOLE_SLOTS > 1) ? $clog2(SOLE_SLOTS) : 1;
	localparam int DW  = POS_WIDTH + 1;
	localparam int AXW = (DW > fsfs_pkg::MAG_W + 1) ? DW : fsfs_pkg::MAG_W + 1;
	localparam int CW  = ((POS_WIDTH > fsfs_pkg::FLOOR_W + 1) ? POS_WIDTH
		: fsfs_pkg::FLOOR_W + 1) + 1;
	localparam logic [4:0] SLOTS_LIM = 5'(SOLE_SLOTS);

	// Slot history.
	logic signed [POS_WIDTH-1:0] last_x_q [SOLE_SLOTS];
	logic signed [POS_WIDTH-1:0] last_y_q [SOLE_SLOTS];
	logic signed [POS_WIDTH-1:0] last_z_q [SOLE_SLOTS];
	logic [SOLE_SLOTS-1:0]       has_last_q;

	// Item registers.
	logic [SW-1:0]                   idx_q;
	logic                            in_use_q;
	logic                            valid_q;
	logic                            has_q;
	logic signed [POS_WIDTH-1:0]     x_q;
	logic signed [POS_WIDTH-1:0]     y_q;
	logic signed [POS_WIDTH-1:0]     z_q;
	logic [fsfs_pkg::MAG_W-1:0]      ax_q;
	logic [fsfs_pkg::MAG_W-1:0]      ay_q;
	logic [fsfs_pkg::MAG_W-1:0]      az_q;
	logic                            far_q;
	logic [fsfs_pkg::P_W-1:0]        p_q;
	logic [fsfs_pkg::P2_W-1:0]       p2_q;
	logic [fsfs_pkg::ACC_W-1:0]      acc_q;
	logic signed [POS_WIDTH-1:0]     height_q;
	logic                            changed_q;

	logic                            in_use;
	logic [SW-1:0]                   rd_idx;
	logic [fsfs_pkg::DT_W-1:0]       dt;
	logic signed [DW-1:0]            dx, dy, dz;
	logic [DW-1:0]                   mx, my, mz;
	logic [AXW-1:0]                  ex, ey, ez;
	logic                            far;
	logic [fsfs_pkg::MAG_W-1:0]      mul_op;
	logic [2*fsfs_pkg::MAG_W-1:0]    sq;
	logic [fsfs_pkg::P_W:0]          thr;
	logic                            slow;
	logic signed [CW-1:0]            zc, fc, bc, top_c;
	logic                            below, in_band;
	logic signed [POS_WIDTH-1:0]     h_res;
	logic                            ch_res;

	assign in_use = ({2'b00, slot} < SLOTS_LIM) && (slot < cfg.slots_in_use);
	assign rd_idx = in_use ? SW'(slot) : '0;
	assign dt     = (frame_interval < fsfs_pkg::DT_MIN) ? fsfs_pkg::DT_MIN : frame_interval;

	assign dx = {pos_x[POS_WIDTH-1], pos_x} - {last_x_q[rd_idx][POS_WIDTH-1], last_x_q[rd_idx]};
	assign dy = {pos_y[POS_WIDTH-1], pos_y} - {last_y_q[rd_idx][POS_WIDTH-1], last_y_q[rd_idx]};
	assign dz = {pos_z[POS_WIDTH-1], pos_z} - {last_z_q[rd_idx][POS_WIDTH-1], last_z_q[rd_idx]};
	assign mx = dx[DW-1] ? DW'(-dx) : DW'(dx);
	assign my = dy[DW-1] ? DW'(-dy) : DW'(dy);
	assign mz = dz[DW-1] ? DW'(-dz) : DW'(dz);
	assign ex = AXW'(mx);
	assign ey = AXW'(my);
	assign ez = AXW'(mz);
	// Any axis at or beyond 2^16 already exceeds the largest threshold.
	assign far = (|ex[AXW-1:fsfs_pkg::MAG_W]) | (|ey[AXW-1:fsfs_pkg::MAG_W])
		| (|ez[AXW-1:fsfs_pkg::MAG_W]);

	// One shared squarer steps through the three axes.
	always_comb begin
		if (cmd.sq_x) begin
			mul_op = ax_q;
		end else if (cmd.sq_y) begin
			mul_op = ay_q;
		end else begin
			mul_op = az_q;
		end
	end
	assign sq = mul_op * mul_op;

	// Slow when d2 * 2^32 < p^2, i.e. d2 below the rounded-up high word.
	assign thr  = {1'b0, p2_q[fsfs_pkg::P2_W-1:fsfs_pkg::P_W]}
		+ {{fsfs_pkg::P_W{1'b0}}, |p2_q[fsfs_pkg::P_W-1:0]};
	assign slow = ~far_q && (acc_q < {1'b0, thr});

	assign zc    = {{(CW-POS_WIDTH){z_q[POS_WIDTH-1]}}, z_q};
	assign fc    = {{(CW-fsfs_pkg::FLOOR_W){cfg.floor_height[fsfs_pkg::FLOOR_W-1]}},
		cfg.floor_height};
	assign bc    = {{(CW-fsfs_pkg::BAND_W){1'b0}}, cfg.snap_band};
	assign top_c = fc + bc;
	assign below   = zc < fc;
	assign in_band = zc < top_c;

	always_comb begin
		h_res  = z_q;
		ch_res = 1'b0;
		if (in_use_q && valid_q) begin
			if (below) begin
				h_res  = fc[POS_WIDTH-1:0];
				ch_res = 1'b1;
			end else if (has_q && in_band && slow) begin
				h_res  = fc[POS_WIDTH-1:0];
				ch_res = (zc != fc);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_last_q <= '0;
		end else if (cmd.finish && in_use_q) begin
			has_last_q[idx_q] <= valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			idx_q    <= rd_idx;
			in_use_q <= in_use;
			valid_q  <= point_valid;
			has_q    <= has_last_q[rd_idx];
			x_q      <= pos_x;
			y_q      <= pos_y;
			z_q      <= pos_z;
			ax_q     <= ex[fsfs_pkg::MAG_W-1:0];
			ay_q     <= ey[fsfs_pkg::MAG_W-1:0];
			az_q     <= ez[fsfs_pkg::MAG_W-1:0];
			far_q    <= far;
			p_q      <= fsfs_pkg::P_W'(cfg.stance_speed_limit * dt);
		end
		if (cmd.sq_x) begin
			p2_q  <= fsfs_pkg::P2_W'(p_q) * fsfs_pkg::P2_W'(p_q);
			acc_q <= fsfs_pkg::ACC_W'(sq);
		end
		if (cmd.sq_y || cmd.sq_z) begin
			acc_q <= acc_q + fsfs_pkg::ACC_W'(sq);
		end
		if (cmd.finish) begin
			height_q  <= h_res;
			changed_q <= ch_res;
			if (in_use_q && valid_q) begin
				last_x_q[idx_q] <= x_q;
				last_y_q[idx_q] <= y_q;
				last_z_q[idx_q] <= z_q;
			end
		end
	end

	assign height_out = height_q;
	assign changed    = changed_q;

endmodule

>>> test/foot_sole_floor_snap_unit_tb.sv
// Self-checking testbench of the foot-sole floor snap unit.
// Depends on fsfs_pkg, the fsfs channel interfaces and the unit itself;
// results are predicted in the bench and compared field by field.
module foot_sole_floor_snap_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SOLE_SLOTS  = 6;
	localparam int POS_W       = 20;
	localparam int POS_MIN     = -524288;
	localparam int POS_MAX     = 524287;
	localparam int CYCLE_LIMIT = 500000;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 10;

	localparam int SLOT_W     = fsfs_pkg::SLOT_W;
	localparam int DT_W       = fsfs_pkg::DT_W;
	localparam int FLOOR_W    = fsfs_pkg::FLOOR_W;
	localparam int BAND_W     = fsfs_pkg::BAND_W;
	localparam int SPEED_W    = fsfs_pkg::SPEED_W;
	localparam int SLOTS_W    = fsfs_pkg::SLOTS_W;
	localparam int CFG_DATA_W = fsfs_pkg::CFG_DATA_W;

	localparam longint AXIS_MAX = 65535;

	typedef struct packed {
		logic [SLOT_W-1:0]       slot;
		logic                    point_valid;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
		logic [DT_W-1:0]         frame_interval;
	} sole_point_t;

	typedef struct packed {
		logic signed [POS_W-1:0] height;
		logic                    changed;
	} grounded_t;

	logic clk;
	logic arst_n;

	fsfs_in_if #(.POS_WIDTH(POS_W)) in_ch ();
	fsfs_out_if #(.POS_WIDTH(POS_W)) out_ch ();
	fsfs_cfg_if cfg_ch ();

	foot_sole_floor_snap_unit #(
		.SOLE_SLOTS(SOLE_SLOTS),
		.POS_WIDTH (POS_W)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch),
		.out_ch(out_ch),
		.cfg_ch(cfg_ch)
	);

	// Bench copy of the registers and the per-slot history.
	fsfs_pkg::cfg_t reg_cfg = '{fsfs_pkg::FLOOR_RST, fsfs_pkg::BAND_RST,
		fsfs_pkg::SPEED_RST, fsfs_pkg::SLOTS_RST};
	longint  prev_x [SOLE_SLOTS];
	longint  prev_y [SOLE_SLOTS];
	longint  prev_z [SOLE_SLOTS];
	bit      prev_seen [SOLE_SLOTS];

	// Stimulus tracks, one per slot code, so that points move smoothly.
	logic signed [POS_W-1:0] trk_x [8];
	logic signed [POS_W-1:0] trk_y [8];
	logic signed [POS_W-1:0] trk_z [8];

	grounded_t expected_heights [$];

	int src_idle_pct   = 0;
	int sink_stall_pct = 0;
	int hold_left      = 0;
	int cycle_count    = 0;
	int errors         = 0;
	int n_points       = 0;
	int n_results      = 0;
	int n_grounded     = 0;
	int n_settings     = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding",
				cycle_count, expected_heights.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic grounded_t ground_point(sole_point_t p);
		grounded_t   r;
		longint      flr, h, ax, ay, az;
		logic [63:0] dt, pr, thr, d2, p2;
		bit          slow;
		int          s;
		s = int'(p.slot);
		flr = longint'(reg_cfg.floor_height);
		h = longint'(p.pos_z);
		r.changed = 1'b0;
		dt = 64'((p.frame_interval < fsfs_pkg::DT_MIN) ? fsfs_pkg::DT_MIN : p.frame_interval);
		if (p.slot < reg_cfg.slots_in_use && s < SOLE_SLOTS) begin
			if (!p.point_valid) begin
				prev_seen[s] = 1'b0;
			end else begin
				if (h < flr) begin
					h = flr;
					r.changed = 1'b1;
				end
				ax = longint'(p.pos_x) - prev_x[s];
				ay = longint'(p.pos_y) - prev_y[s];
				az = longint'(p.pos_z) - prev_z[s];
				if (ax < 0) ax = -ax;
				if (ay < 0) ay = -ay;
				if (az < 0) az = -az;
				// Slow when |d|^2 * 2^32 < (limit * dt)^2; the threshold is rounded up.
				pr = 64'(reg_cfg.stance_speed_limit) * dt;
				p2 = pr * pr;
				thr = (p2 >> 32) + 64'(p2[31:0] != 32'd0);
				slow = 1'b0;
				if (ax <= AXIS_MAX && ay <= AXIS_MAX && az <= AXIS_MAX) begin
					d2 = 64'(ax * ax + ay * ay + az * az);
					slow = (d2 < thr);
				end
				if (prev_seen[s] && slow && h >= flr &&
					h < flr + longint'(reg_cfg.snap_band) && h != flr) begin
					h = flr;
					r.changed = 1'b1;
				end
				prev_x[s] = longint'(p.pos_x);
				prev_y[s] = longint'(p.pos_y);
				prev_z[s] = longint'(p.pos_z);
				prev_seen[s] = 1'b1;
			end
		end
		r.height = h[POS_W-1:0];
		return r;
	endfunction

	function automatic int jitter(int a);
		return int'($urandom_range(2 * a)) - a;
	endfunction

	function automatic sole_point_t pt(int s, bit v, int x, int y, int z, int dt);
		sole_point_t p;
		p.slot = SLOT_W'(s);
		p.point_valid = v;
		p.pos_x = POS_W'(x);
		p.pos_y = POS_W'(y);
		p.pos_z = POS_W'(z);
		p.frame_interval = DT_W'(dt);
		return p;
	endfunction

	// Mostly smooth tracks near the floor, with some raw noise mixed in.
	function automatic sole_point_t make_point();
		sole_point_t p;
		int          s;
		int          step;
		if ($urandom_range(99) < 15) begin
			p.slot = SLOT_W'($urandom);
			p.point_valid = 1'($urandom);
			p.pos_x = POS_W'($urandom);
			p.pos_y = POS_W'($urandom);
			p.pos_z = POS_W'($urandom);
			p.frame_interval = DT_W'($urandom);
			return p;
		end
		s = ($urandom_range(99) < 4) ? int'($urandom_range(7, 6)) : int'($urandom_range(5, 0));
		step = ($urandom_range(3) == 0) ? 300 : 6;
		trk_x[s] = POS_W'(int'(trk_x[s]) + jitter(step));
		trk_y[s] = POS_W'(int'(trk_y[s]) + jitter(step));
		if ($urandom_range(3) == 0)
			trk_z[s] = POS_W'(int'(reg_cfg.floor_height) - 200 +
				int'($urandom_range(int'(reg_cfg.snap_band) + 400)));
		else
			trk_z[s] = POS_W'(int'(trk_z[s]) + jitter(step));
		p.slot = SLOT_W'(s);
		p.point_valid = ($urandom_range(99) < 92);
		p.pos_x = trk_x[s];
		p.pos_y = trk_y[s];
		p.pos_z = trk_z[s];
		case ($urandom_range(9))
			0:       p.frame_interval = DT_W'($urandom_range(fsfs_pkg::DT_MIN));
			1:       p.frame_interval = DT_W'($urandom);
			default: p.frame_interval = DT_W'($urandom_range(2500, 200));
		endcase
		return p;
	endfunction

	function automatic fsfs_pkg::cfg_t random_cfg();
		fsfs_pkg::cfg_t c;
		c.floor_height = ($urandom_range(3) == 0) ? FLOOR_W'($urandom) : FLOOR_W'(jitter(3000));
		case ($urandom_range(5))
			0:       c.snap_band = '0;
			1:       c.snap_band = '1;
			default: c.snap_band = BAND_W'($urandom_range(3000, 40));
		endcase
		case ($urandom_range(5))
			0:       c.stance_speed_limit = '0;
			1:       c.stance_speed_limit = '1;
			default: c.stance_speed_limit = SPEED_W'($urandom_range(6000, 300));
		endcase
		c.slots_in_use = ($urandom_range(2) == 0) ? SLOTS_W'($urandom_range(7))
			: SLOTS_W'(SOLE_SLOTS);
		return c;
	endfunction

	task automatic send_point(sole_point_t p);
		while ($urandom_range(99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.slot <= p.slot;
		in_ch.point_valid <= p.point_valid;
		in_ch.pos_x <= p.pos_x;
		in_ch.pos_y <= p.pos_y;
		in_ch.pos_z <= p.pos_z;
		in_ch.frame_interval <= p.frame_interval;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		expected_heights.push_back(ground_point(p));
		n_points++;
	endtask

	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		while (expected_heights.size() != 0) @(posedge clk);
	endtask

	// Writes all four registers back to back; unused high data bits carry noise.
	task automatic write_regs(fsfs_pkg::cfg_t c);
		logic [CFG_DATA_W-1:0] pad;
		fsfs_pkg::reg_idx_t    idx;
		idx = fsfs_pkg::REG_FLOOR_HEIGHT;
		repeat (4) begin
			pad = CFG_DATA_W'($urandom);
			case (idx)
				fsfs_pkg::REG_FLOOR_HEIGHT: cfg_ch.data <= c.floor_height;
				fsfs_pkg::REG_SNAP_BAND:
					cfg_ch.data <= {pad[CFG_DATA_W-1:BAND_W], c.snap_band};
				fsfs_pkg::REG_STANCE_SPEED:
					cfg_ch.data <= {pad[CFG_DATA_W-1:SPEED_W], c.stance_speed_limit};
				fsfs_pkg::REG_SLOTS_IN_USE:
					cfg_ch.data <= {pad[CFG_DATA_W-1:SLOTS_W], c.slots_in_use};
				default: cfg_ch.data <= pad;
			endcase
			cfg_ch.index <= idx;
			cfg_ch.valid <= 1'b1;
			do @(posedge clk); while (cfg_ch.ready !== 1'b1);
			idx = idx.next();
		end
		cfg_ch.valid <= 1'b0;
		reg_cfg = c;
		n_settings++;
	endtask

	task automatic run_phase(int n, int src_pct, int sink_pct);
		wait_idle();
		write_regs(random_cfg());
		src_idle_pct = src_pct;
		sink_stall_pct = sink_pct;
		repeat (n) send_point(make_point());
	endtask

	// Reset defaults first, then the register extremes.
	task automatic test_directed();
		send_point(pt(0, 1, 0, 0, 50, 1000));
		send_point(pt(0, 1, 0, 0, 50, 1000));
		send_point(pt(0, 1, 0, 0, -100, 1000));
		send_point(pt(1, 1, POS_MIN, POS_MAX, POS_MAX, 0));
		send_point(pt(1, 1, POS_MAX, POS_MIN, POS_MIN, 65535));
		send_point(pt(2, 1, 3, -3, 122, 65535));
		send_point(pt(2, 1, 3, -3, 122, 65));
		send_point(pt(2, 1, 3, -3, 123, 66));
		send_point(pt(2, 0, POS_MIN, POS_MIN, POS_MIN, 0));
		send_point(pt(2, 1, 3, -3, 10, 1000));
		send_point(pt(6, 1, 0, 0, -5, 1000));
		send_point(pt(7, 0, 0, 0, -5, 1000));
		wait_idle();
		write_regs('{20'sh80000, 19'h7FFFF, 16'hFFFF, 3'd7});
		send_point(pt(5, 1, 100, 100, POS_MIN + 10, 0));
		send_point(pt(5, 1, 101, 99, POS_MIN + 12, 500));
		send_point(pt(6, 1, 0, 0, POS_MIN, 100));
		send_point(pt(4, 1, 0, 0, -1, 100));
		send_point(pt(4, 1, 0, 0, -2, 100));
		send_point(pt(4, 1, 0, 0, -1, 100));
		wait_idle();
		write_regs('{20'sh7FFFF, 19'd0, 16'd0, 3'd0});
		send_point(pt(0, 1, 0, 0, -3, 1000));
		wait_idle();
		write_regs('{20'sh7FFFF, 19'd5, 16'd0, 3'd6});
		send_point(pt(0, 1, 0, 0, -3, 1000));
		send_point(pt(0, 1, 0, 0, POS_MAX, 1000));
	endtask

	task automatic test_streaming();
		run_phase(130, 0, 0);
		run_phase(130, 0, 0);
	endtask

	task automatic test_sender_gaps();
		run_phase(130, 59, 0);
		run_phase(130, 59, 0);
	endtask

	task automatic test_receiver_stalls();
		run_phase(130, 0, 59);
		run_phase(130, 0, 59);
	endtask

	task automatic test_both_idle();
		run_phase(130, 9, 9);
		run_phase(130, 9, 9);
	endtask

	// The receiver holds off long enough for the unit to fill and stall its input.
	task automatic test_backpressure();
		wait_idle();
		write_regs(random_cfg());
		src_idle_pct = 0;
		sink_stall_pct = 0;
		hold_left = HOLD_CYCLES;
		repeat (40) send_point(make_point());
		src_idle_pct = 30;
		sink_stall_pct = 30;
		repeat (220) send_point(make_point());
	endtask

	// Receiver: checks each transfer and then decides the next ready.
	initial begin
		grounded_t want;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
				if (expected_heights.size() == 0) begin
					errors++;
					$display("%0t: result with none expected: height %0d changed %0b",
						$time, out_ch.height_out, out_ch.changed);
				end else begin
					want = expected_heights.pop_front();
					n_results++;
					if (want.changed) n_grounded++;
					if (out_ch.height_out !== want.height) begin
						errors++;
						$display("%0t: height_out expected %0d, actual %0d",
							$time, want.height, out_ch.height_out);
					end
					if (out_ch.changed !== want.changed) begin
						errors++;
						$display("%0t: changed expected %0b, actual %0b",
							$time, want.changed, out_ch.changed);
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	initial begin
		for (int i = 0; i < 8; i++) begin
			trk_x[i] = POS_W'(jitter(2000));
			trk_y[i] = POS_W'(jitter(2000));
			trk_z[i] = POS_W'(jitter(100));
		end
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.slot <= '0;
		in_ch.point_valid <= 1'b0;
		in_ch.pos_x <= '0;
		in_ch.pos_y <= '0;
		in_ch.pos_z <= '0;
		in_ch.frame_interval <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= fsfs_pkg::REG_FLOOR_HEIGHT;
		cfg_ch.data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_streaming();
		test_sender_gaps();
		test_receiver_stalls();
		test_both_idle();
		test_backpressure();

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Sent %0d sole points over %0d register settings and idle patterns.",
			n_points, n_settings);
		$display("Checked %0d results, %0d of them clamped or snapped; %0d errors.",
			n_results, n_grounded, errors);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
